[hw/rtl/pbrd_pkg.sv]
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared types, constants and width decode helpers of the patched-base decoder.
// ----------------------------------------------------------------------------
package pbrd_pkg;

	localparam int MAX_RUN_DEF     = 512;
	localparam int MAX_PATCHES_DEF = 32;

	typedef struct packed {
		logic hdr_shift;
		logic base_shift;
		logic load_byte;
		logic bit_step;
		logic pat_sel;
		logic emit_init;
		logic emit_out;
		logic seek_step;
		logic err_out;
		logic start_run;
	} pbrd_cmd_t;

	typedef struct packed {
		logic hdr_last;
		logic hdr_bad;
		logic base_last;
		logic all_done;
		logic byte_end;
		logic emit_last;
		logic patched;
		logic seek_done;
		logic out_busy;
	} pbrd_stat_t;

	function automatic logic [6:0] width_code(input logic [4:0] c);
		logic [6:0] w;
		case (c)
			5'd24:   w = 7'd26;
			5'd25:   w = 7'd28;
			5'd26:   w = 7'd30;
			5'd27:   w = 7'd32;
			5'd28:   w = 7'd40;
			5'd29:   w = 7'd48;
			5'd30:   w = 7'd56;
			5'd31:   w = 7'd64;
			default: w = {2'b00, c} + 7'd1;
		endcase
		return w;
	endfunction

	function automatic logic [6:0] fixed_width(input logic [6:0] n);
		logic [6:0] w;
		if (n == 7'd0)       w = 7'd1;
		else if (n <= 7'd24) w = n;
		else if (n <= 7'd26) w = 7'd26;
		else if (n <= 7'd28) w = 7'd28;
		else if (n <= 7'd30) w = 7'd30;
		else if (n <= 7'd32) w = 7'd32;
		else if (n <= 7'd40) w = 7'd40;
		else if (n <= 7'd48) w = 7'd48;
		else if (n <= 7'd56) w = 7'd56;
		else                 w = 7'd64;
		return w;
	endfunction

endpackage

[hw/rtl/pbrd_in_if.sv]
// ----------------------------------------------------------------------------
// pbrd_in_if
// Input stream: data bytes and pull requests.
// ----------------------------------------------------------------------------
interface pbrd_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, kind, data_byte, input ready);
	modport sink (input valid, kind, data_byte, output ready);
endinterface

[hw/rtl/pbrd_out_if.sv]
// ----------------------------------------------------------------------------
// pbrd_out_if
// Output stream: decoded values.
// ----------------------------------------------------------------------------
interface pbrd_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic [16:0]        position;
	logic               last;
	logic               error;

	modport source (output valid, value, position, last, error, input ready);
	modport sink (input valid, value, position, last, error, output ready);
endinterface

[hw/rtl/pbrd_datapath.sv]
// ----------------------------------------------------------------------------
// pbrd_datapath
// Header/base registers, bit unpacker, value and patch stores, patch seek
// and the output register.
// ----------------------------------------------------------------------------
module pbrd_datapath
	import pbrd_pkg::*;
#(
	parameter int MAX_RUN     = MAX_RUN_DEF,
	parameter int MAX_PATCHES = MAX_PATCHES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic [7:0]         in_byte,
	input  pbrd_cmd_t          cmd,
	output pbrd_stat_t         st,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] out_value,
	output logic [16:0]        out_position,
	output logic               out_last,
	output logic               out_error
);

	localparam int AW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int PAW = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
	localparam int MX  = (MAX_RUN > MAX_PATCHES) ? MAX_RUN : MAX_PATCHES;
	localparam int CW  = $clog2(MX + 1);
	localparam int PIW = $clog2(MAX_PATCHES + 1);

	logic [15:0]     fp_q;
	logic [31:0]     hdr_q;
	logic [3:0]      cnt_q;
	logic [63:0]     base_q;
	logic [63:0]     acc_q;
	logic [6:0]      held_q;
	logic [CW-1:0]   items_q;
	logic [7:0]      byte_q;
	logic [3:0]      rem_q;
	logic [AW-1:0]   emit_q;
	logic [PIW-1:0]  pidx_q;
	logic [15:0]     npp_q;
	logic [15:0]     sacc_q;
	logic [AW-1:0]   spos_q;
	logic [63:0]     rd_q;
	logic            ov_q;
	logic [63:0]     vmem [MAX_RUN];
	logic [63:0]     pat_q [MAX_PATCHES];

	logic [7:0]  b0, b1, b2, b3;
	logic [6:0]  vw, pw, w;
	logic [3:0]  bb, gw;
	logic [4:0]  pc;
	logic [9:0]  rl, target;
	logic [31:0] hdr_n;
	logic        hdr_bad;
	logic [63:0] base_n, sign_m, pmask;
	logic [6:0]  need, held_n;
	logic [3:0]  k;
	logic [7:0]  take;
	logic        full;
	logic [CW-1:0] items_n;
	logic [63:0] ent, gap, pbits, vpat;
	logic        chain, pidx_ok;
	logic [65:0] ssum;
	logic [15:0] npp_n;

	assign b0 = hdr_q[31:24];
	assign b1 = hdr_q[23:16];
	assign b2 = hdr_q[15:8];
	assign b3 = hdr_q[7:0];
	assign vw = width_code(b0[5:1]);
	assign rl = {1'b0, b0[0], b1} + 10'd1;
	assign bb = {1'b0, b2[7:5]} + 4'd1;
	assign pw = width_code(b2[4:0]);
	assign gw = {1'b0, b3[7:5]} + 4'd1;
	assign pc = b3[4:0];

	assign hdr_n = {hdr_q[23:0], in_byte};
	always_comb begin
		logic [6:0] npw, ngw;
		logic [9:0] nrl;
		npw = width_code(hdr_n[12:8]);
		ngw = {4'd0, hdr_n[7:5]} + 7'd1;
		nrl = {1'b0, hdr_n[24], hdr_n[23:16]} + 10'd1;
		hdr_bad = (hdr_n[4:0] == 5'd0) || ((npw + ngw) > 7'd64) ||
			(int'(nrl) > MAX_RUN) || (int'(hdr_n[4:0]) > MAX_PATCHES);
	end
	assign st.hdr_bad   = hdr_bad;
	assign st.hdr_last  = (cnt_q == 4'd3);
	assign st.base_last = (cnt_q == (4'd3 + bb));

	assign base_n = {base_q[55:0], in_byte};
	assign sign_m = 64'd1 << ({bb[2:0], 3'b000} + 6'd63);

	// Chunked bit unpacker: up to the rest of the byte or the item, per cycle.
	assign w       = cmd.pat_sel ? fixed_width(pw + {3'b000, gw}) : vw;
	assign target  = cmd.pat_sel ? {5'd0, pc} : rl;
	assign need    = w - held_q;
	assign k       = (need < {3'b000, rem_q}) ? need[3:0] : rem_q;
	assign take    = byte_q >> (4'd8 - k);
	assign held_n  = held_q + {3'b000, k};
	assign full    = (held_n == w);
	assign items_n = items_q + CW'(1);
	assign st.all_done = full && (int'(items_n) >= int'(target));
	assign st.byte_end = (rem_q == k);

	assign pmask   = (pw >= 7'd64) ? '1 : ((64'd1 << pw) - 64'd1);
	assign pidx_ok = int'(pidx_q) < int'(pc);
	assign ent     = pat_q[pidx_q[PAW-1:0]];
	assign gap     = (pw >= 7'd64) ? 64'd0 : (ent >> pw);
	assign pbits   = ent & pmask;
	assign chain   = (gap == 64'd255) && (pbits == 64'd0);
	assign ssum    = {2'b00, gap} + {50'd0, sacc_q} + 66'(spos_q);
	assign npp_n   = (ssum > 66'hffff) ? 16'hffff : ssum[15:0];
	assign st.seek_done = !pidx_ok || !chain;

	assign st.patched   = pidx_ok && (16'(emit_q) == npp_q);
	assign st.emit_last = (int'(emit_q) + 1) >= int'(rl);
	assign vpat = (st.patched && vw < 7'd64) ? (pbits << vw) : 64'd0;

	assign st.out_busy = ov_q && !out_ready;
	assign out_valid   = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q    <= '0;
			hdr_q   <= '0;
			cnt_q   <= '0;
			base_q  <= '0;
			acc_q   <= '0;
			held_q  <= '0;
			items_q <= '0;
			rem_q   <= '0;
			emit_q  <= '0;
			pidx_q  <= '0;
			npp_q   <= '0;
			sacc_q  <= '0;
			spos_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we)
				fp_q <= cfg_data;
			ov_q <= cmd.err_out || cmd.emit_out || (ov_q && !out_ready);
			if (cmd.hdr_shift) begin
				hdr_q <= hdr_n;
				cnt_q <= cnt_q + 4'd1;
			end
			if (cmd.base_shift) begin
				cnt_q <= cnt_q + 4'd1;
				if (st.base_last) begin
					base_q  <= ((base_n & sign_m) != 64'd0) ?
						(64'd0 - (base_n & ~sign_m)) : base_n;
					acc_q   <= '0;
					held_q  <= '0;
					items_q <= '0;
				end else begin
					base_q <= base_n;
				end
			end
			if (cmd.load_byte)
				rem_q <= 4'd8;
			if (cmd.bit_step) begin
				rem_q <= rem_q - k;
				if (full) begin
					acc_q   <= '0;
					held_q  <= '0;
					items_q <= st.all_done ? '0 : items_n;
				end else begin
					acc_q  <= (acc_q << k) | {56'd0, take};
					held_q <= held_n;
				end
			end
			if (cmd.emit_init) begin
				emit_q <= '0;
				pidx_q <= '0;
				sacc_q <= '0;
				spos_q <= '0;
			end
			if (cmd.seek_step) begin
				if (!pidx_ok) begin
					pidx_q <= PIW'(pc);
				end else if (chain) begin
					sacc_q <= sacc_q + 16'd255;
					pidx_q <= pidx_q + PIW'(1);
				end else begin
					npp_q <= npp_n;
				end
			end
			if (cmd.emit_out && !st.emit_last) begin
				emit_q <= emit_q + AW'(1);
				if (st.patched) begin
					pidx_q <= pidx_q + PIW'(1);
					sacc_q <= '0;
					spos_q <= emit_q;
				end
			end
			if (cmd.start_run) begin
				hdr_q   <= '0;
				cnt_q   <= '0;
				base_q  <= '0;
				acc_q   <= '0;
				held_q  <= '0;
				items_q <= '0;
				emit_q  <= '0;
				pidx_q  <= '0;
				npp_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= vmem[emit_q];
		if (cmd.load_byte)
			byte_q <= in_byte;
		if (cmd.bit_step) begin
			byte_q <= byte_q << k;
			if (full) begin
				if (cmd.pat_sel)
					pat_q[items_q[PAW-1:0]] <= (acc_q << k) | {56'd0, take};
				else
					vmem[items_q[AW-1:0]] <= (acc_q << k) | {56'd0, take};
			end
		end
		if (cmd.err_out) begin
			out_value    <= '0;
			out_position <= {1'b0, fp_q};
			out_last     <= 1'b1;
			out_error    <= 1'b1;
		end
		if (cmd.emit_out) begin
			out_value    <= base_q + (rd_q | vpat);
			out_position <= 17'(fp_q) + 17'(emit_q);
			out_last     <= st.emit_last;
			out_error    <= 1'b0;
		end
	end

endmodule

[hw/rtl/pbrd_ctrl.sv]
// ----------------------------------------------------------------------------
// pbrd_ctrl
// Run phase and step sequencer of the patched-base decoder.
// ----------------------------------------------------------------------------
module pbrd_ctrl
	import pbrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_kind,
	output logic       in_ready,
	input  pbrd_stat_t st,
	output pbrd_cmd_t  cmd
);

	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_BASE = 3'd1;
	localparam logic [2:0] PH_VALS = 3'd2;
	localparam logic [2:0] PH_PAT  = 3'd3;
	localparam logic [2:0] PH_EMIT = 3'd4;
	localparam logic [2:0] PH_ERR  = 3'd5;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_BITS = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;
	localparam logic [1:0] S_SEEK = 2'd3;

	logic [2:0] phase_q, phase_n;
	logic [1:0] step_q, step_n;
	logic       fire;

	assign in_ready = (step_q == S_IDLE) && !st.out_busy;
	assign fire     = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		phase_n = phase_q;
		step_n  = step_q;
		case (step_q)
			S_IDLE: begin
				if (fire && !in_kind) begin
					case (phase_q)
						PH_HDR: begin
							cmd.hdr_shift = 1'b1;
							if (st.hdr_last)
								phase_n = st.hdr_bad ? PH_ERR : PH_BASE;
						end
						PH_BASE: begin
							cmd.base_shift = 1'b1;
							if (st.base_last)
								phase_n = PH_VALS;
						end
						PH_VALS, PH_PAT: begin
							cmd.load_byte = 1'b1;
							step_n = S_BITS;
						end
						default: ;
					endcase
				end else if (fire && in_kind) begin
					if (phase_q == PH_ERR) begin
						cmd.err_out   = 1'b1;
						cmd.start_run = 1'b1;
						phase_n = PH_HDR;
					end else if (phase_q == PH_EMIT) begin
						step_n = S_OUT;
					end
				end
			end
			S_BITS: begin
				cmd.bit_step = 1'b1;
				cmd.pat_sel  = (phase_q == PH_PAT);
				if (st.all_done) begin
					if (phase_q == PH_PAT) begin
						phase_n = PH_EMIT;
						cmd.emit_init = 1'b1;
						step_n = S_SEEK;
					end else begin
						phase_n = PH_PAT;
						step_n = S_IDLE;
					end
				end else if (st.byte_end) begin
					step_n = S_IDLE;
				end
			end
			S_OUT: begin
				cmd.emit_out = 1'b1;
				if (st.emit_last) begin
					cmd.start_run = 1'b1;
					phase_n = PH_HDR;
					step_n = S_IDLE;
				end else begin
					step_n = st.patched ? S_SEEK : S_IDLE;
				end
			end
			S_SEEK: begin
				cmd.seek_step = 1'b1;
				if (st.seek_done)
					step_n = S_IDLE;
			end
			default: step_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			step_q  <= S_IDLE;
		end else begin
			phase_q <= phase_n;
			step_q  <= step_n;
		end
	end

endmodule

[hw/rtl/patched_base_run_decoder_core.sv]
// Header, base and malformed-run bytes: consumed at the transfer, with no further step.
// Packed value and patch bytes: the transfer, then S_BITS unpacks the byte piece by piece;
// no new byte is taken until it is spent or the section ends. Pull: the transfer moves the
// sequencer to S_OUT, which registers the result; after a patched value S_SEEK walks the
// patch list (chained 255 gaps). Malformed header pull: result registered at its transfer edge.
// arst_n clears the sequencer, counters and output valid; stores are undefined until loaded.
// ----------------------------------------------------------------------------
// patched_base_run_decoder_core
// Top level: sequencer plus datapath for one patched-base run at a time.
// ----------------------------------------------------------------------------
module patched_base_run_decoder_core
	import pbrd_pkg::*;
#(
	parameter int MAX_RUN     = MAX_RUN_DEF,
	parameter int MAX_PATCHES = MAX_PATCHES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	pbrd_in_if.sink     in_ch,
	pbrd_out_if.source  out_ch
);

	pbrd_cmd_t  cmd;
	pbrd_stat_t st;

	pbrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	pbrd_datapath #(
		.MAX_RUN     (MAX_RUN),
		.MAX_PATCHES (MAX_PATCHES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_byte      (in_ch.data_byte),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_value    (out_ch.value),
		.out_position (out_ch.position),
		.out_last     (out_ch.last),
		.out_error    (out_ch.error)
	);

endmodule

[hw/rtl/pbrd_checker.sv]
// ----------------------------------------------------------------------------
// pbrd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pbrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_value,
	input logic        out_last,
	input logic        out_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("result changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_last && out_value == 64'd0)
		else $error("error result malformed");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !(out_valid && !out_ready))
		else $error("transfer taken while result stalled");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_kind) ||
			$past(in_valid && in_ready && in_kind, 2))
		else $error("result without pull");

endmodule

bind patched_base_run_decoder_core pbrd_checker u_pbrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_kind   (in_ch.kind),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.value),
	.out_last  (out_ch.last),
	.out_error (out_ch.error)
);
